// File: rtl/core/abv2d_pkg.sv
// Shared types, widths and the CORDIC arctangent table for the vector angle block.
`timescale 1ns / 1ps
package abv2d_pkg;

  localparam int unsigned COMP_W     = 16;  // width of one Q8.8 vector component
  localparam int unsigned ANGLE_FRAC = 8;   // fraction bits of the result angle
  localparam int unsigned ANGLE_W    = 8 + ANGLE_FRAC;
  localparam int unsigned PROD_W     = 2 * COMP_W;      // signed product width
  localparam int unsigned SUM_W      = PROD_W + 1;      // signed dot or cross width
  localparam int unsigned MAG_W      = PROD_W;          // magnitude of dot or cross
  localparam int unsigned NORM_BIT   = 40;              // leading one after normalizing
  localparam int unsigned SH_W       = 6;
  localparam int unsigned XY_W       = NORM_BIT + 4;    // room for CORDIC gain and sign
  localparam int unsigned Z_W        = 32;
  localparam int unsigned ZFRAC      = 22;
  localparam int unsigned STEPS      = 24;
  localparam int unsigned RND_SH     = ZFRAC - ANGLE_FRAC;

  localparam logic signed [Z_W-1:0] Z_90    = Z_W'(90) <<< ZFRAC;
  localparam logic signed [Z_W-1:0] Z_180   = Z_W'(180) <<< ZFRAC;
  localparam logic [ANGLE_W-1:0]    ANG_MAX = ANGLE_W'(180) << ANGLE_FRAC;

  // Control that travels alongside each item in the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;   // either vector has zero length
  } meta_t;

  typedef logic signed [Z_W-1:0] zval_t;

  // atan(2^-i) in degrees, Q.22, rounded to the nearest.
  localparam zval_t ATAN_Q22 [STEPS] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485, 32'sd15000234,
    32'sd7507429,   32'sd3754631,   32'sd1877430,  32'sd938729,   32'sd469366,
    32'sd234683,    32'sd117342,    32'sd58671,    32'sd29335,    32'sd14668,
    32'sd7334,      32'sd3667,      32'sd1833,     32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29
  };

endpackage

// File: rtl/core/abv2d_cordic_stage.sv
// One registered CORDIC vectoring iteration with a fixed shift.
`timescale 1ns / 1ps
module abv2d_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  abv2d_pkg::meta_t                      meta_i,
  input  logic signed [abv2d_pkg::XY_W-1:0]     x_i,
  input  logic signed [abv2d_pkg::XY_W-1:0]     y_i,
  input  abv2d_pkg::zval_t                      z_i,
  output abv2d_pkg::meta_t                      meta_o,
  output logic signed [abv2d_pkg::XY_W-1:0]     x_o,
  output logic signed [abv2d_pkg::XY_W-1:0]     y_o,
  output abv2d_pkg::zval_t                      z_o
);

  logic signed [abv2d_pkg::XY_W-1:0] xs, ys, x_nxt, y_nxt;
  abv2d_pkg::zval_t                  z_nxt;
  abv2d_pkg::meta_t                  meta_r;
  logic signed [abv2d_pkg::XY_W-1:0] x_r, y_r;
  abv2d_pkg::zval_t                  z_r;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  always_comb begin
    if (!y_i[abv2d_pkg::XY_W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + abv2d_pkg::ATAN_Q22[STEP];
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - abv2d_pkg::ATAN_Q22[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else if (en) begin
      meta_r <= meta_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign meta_o = meta_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule

// File: rtl/core/angle_between_vectors_2d.sv
// Top level: pipelined angle between two 2D vectors, in degrees.
//
// Usage. An item is a pair of vectors (in_a_x, in_a_z) and (in_b_x, in_b_z),
// each component signed Q8.8. It is taken at a rising edge where in_valid is
// high and in_stall is low. The result out_angle_deg is the unsigned angle
// between the vectors in degrees, Q8.8, from 0 to 180; it is taken at an
// edge where out_valid is high and out_stall is low. A pair in which either
// vector has zero length gives 0.
// The block takes one item in every cycle while in_stall is low. Its stages
// are four product multipliers, a sum stage, a select and leading-one stage,
// a normalizing shift, 24 CORDIC iterations in stages of their own and a
// rounding stage that is also the output register.
// The whole pipeline advances together. When the receiver stalls a valid
// result, every stage holds and in_stall is raised, so nothing is lost or
// repeated; bubbles move on while the output is empty or being taken.
// A synchronous reset (rst_n low) clears all valid bits; no state is carried
// from one item to the next.
`timescale 1ns / 1ps
module angle_between_vectors_2d (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [abv2d_pkg::COMP_W-1:0]    in_a_x,
  input  logic signed [abv2d_pkg::COMP_W-1:0]    in_a_z,
  input  logic signed [abv2d_pkg::COMP_W-1:0]    in_b_x,
  input  logic signed [abv2d_pkg::COMP_W-1:0]    in_b_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [abv2d_pkg::ANGLE_W-1:0]          out_angle_deg
);

  localparam int unsigned XY_W  = abv2d_pkg::XY_W;
  localparam int unsigned STEPS = abv2d_pkg::STEPS;

  logic adv;

  // Stage 1: the four products.
  abv2d_pkg::meta_t                       m1_r;
  logic signed [abv2d_pkg::PROD_W-1:0]    pxx_r, pzz_r, pxz_r, pzx_r;
  // Stage 2: dot and cross.
  abv2d_pkg::meta_t                       m2_r;
  logic signed [abv2d_pkg::SUM_W-1:0]     dot_r, crs_r;
  logic signed [abv2d_pkg::SUM_W-1:0]     dot_nxt, crs_nxt;
  // Stage 3: rotated operands and normalizing shift.
  abv2d_pkg::meta_t                       m3_r;
  logic [abv2d_pkg::MAG_W-1:0]            ux_r, uy_r, ux_nxt, uy_nxt, mx, dmag, cmag;
  logic                                   rot_r;
  logic [abv2d_pkg::SH_W-1:0]             sh_r, sh_nxt;
  logic [4:0]                             msb;
  // Stage 4 and the CORDIC chain.
  abv2d_pkg::meta_t                       cm [STEPS+1];
  logic signed [XY_W-1:0]                 cx [STEPS+1];
  logic signed [XY_W-1:0]                 cy [STEPS+1];
  abv2d_pkg::zval_t                       cz [STEPS+1];
  abv2d_pkg::meta_t                       m4_r;
  logic signed [XY_W-1:0]                 x4_r, y4_r;
  abv2d_pkg::zval_t                       z4_r;
  // Output stage.
  logic                                   out_valid_r;
  logic [abv2d_pkg::ANGLE_W-1:0]          angle_r, angle_nxt;
  abv2d_pkg::zval_t                       zc;
  logic [abv2d_pkg::Z_W-1:0]              zr;

  // Every stage moves unless a finished result is being held back.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r        <= '0;
      m2_r        <= '0;
      m3_r        <= '0;
      m4_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m1_r.valid  <= in_valid;
      m1_r.zero   <= 1'b0;
      m2_r        <= '{valid: m1_r.valid, zero: (dot_nxt == '0) && (crs_nxt == '0)};
      m3_r        <= m2_r;
      m4_r        <= m3_r;
      out_valid_r <= cm[STEPS].valid;
    end
  end

  // Stage 1.
  always_ff @(posedge clk) begin
    if (adv) begin
      pxx_r <= in_a_x * in_b_x;
      pzz_r <= in_a_z * in_b_z;
      pxz_r <= in_a_x * in_b_z;
      pzx_r <= in_a_z * in_b_x;
    end
  end

  // Stage 2: dot = ax*bx + az*bz, cross = ax*bz - az*bx.
  assign dot_nxt = abv2d_pkg::SUM_W'(pxx_r) + abv2d_pkg::SUM_W'(pzz_r);
  assign crs_nxt = abv2d_pkg::SUM_W'(pxz_r) - abv2d_pkg::SUM_W'(pzx_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_r <= dot_nxt;
      crs_r <= crs_nxt;
    end
  end

  // Stage 3: a negative dot turns the pair by -90 degrees, then the leading
  // one of the larger operand sets the left shift up to the normalizing bit.
  always_comb begin
    dmag = dot_r[abv2d_pkg::SUM_W-1] ? abv2d_pkg::MAG_W'(-dot_r)
                                     : abv2d_pkg::MAG_W'(dot_r);
    cmag = crs_r[abv2d_pkg::SUM_W-1] ? abv2d_pkg::MAG_W'(-crs_r)
                                     : abv2d_pkg::MAG_W'(crs_r);
    if (dot_r[abv2d_pkg::SUM_W-1]) begin
      ux_nxt = cmag;
      uy_nxt = dmag;
    end else begin
      ux_nxt = dmag;
      uy_nxt = cmag;
    end
    mx  = (ux_nxt > uy_nxt) ? ux_nxt : uy_nxt;
    msb = '0;
    for (int i = 0; i < abv2d_pkg::MAG_W; i++) begin
      if (mx[i]) begin
        msb = 5'(i);
      end
    end
    sh_nxt = abv2d_pkg::SH_W'(abv2d_pkg::NORM_BIT) - abv2d_pkg::SH_W'(msb);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux_r  <= ux_nxt;
      uy_r  <= uy_nxt;
      rot_r <= dot_r[abv2d_pkg::SUM_W-1];
      sh_r  <= sh_nxt;
    end
  end

  // Stage 4: normalize and seed the angle.
  always_ff @(posedge clk) begin
    if (adv) begin
      x4_r <= XY_W'(ux_r) <<< sh_r;
      y4_r <= XY_W'(uy_r) <<< sh_r;
      z4_r <= rot_r ? abv2d_pkg::Z_90 : '0;
    end
  end

  assign cm[0] = m4_r;
  assign cx[0] = x4_r;
  assign cy[0] = y4_r;
  assign cz[0] = z4_r;

  for (genvar g = 0; g < STEPS; g++) begin : g_cordic
    abv2d_cordic_stage #(
      .STEP(g)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .meta_i (cm[g]),
      .x_i    (cx[g]),
      .y_i    (cy[g]),
      .z_i    (cz[g]),
      .meta_o (cm[g+1]),
      .x_o    (cx[g+1]),
      .y_o    (cy[g+1]),
      .z_o    (cz[g+1])
    );
  end

  // Output stage: clamp to [0, 180], round half up, clamp again.
  always_comb begin
    if (cz[STEPS] < 0) begin
      zc = '0;
    end else if (cz[STEPS] > abv2d_pkg::Z_180) begin
      zc = abv2d_pkg::Z_180;
    end else begin
      zc = cz[STEPS];
    end
    zr = (abv2d_pkg::Z_W'(zc) + (abv2d_pkg::Z_W'(1) << (abv2d_pkg::RND_SH - 1)))
         >> abv2d_pkg::RND_SH;
    if (cm[STEPS].zero) begin
      angle_nxt = '0;
    end else if (zr > abv2d_pkg::Z_W'(abv2d_pkg::ANG_MAX)) begin
      angle_nxt = abv2d_pkg::ANG_MAX;
    end else begin
      angle_nxt = abv2d_pkg::ANGLE_W'(zr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_angle_deg = angle_r;

  // A result never exceeds 180 degrees.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_deg <= abv2d_pkg::ANG_MAX)
    else $error("angle above 180 degrees");

  // A zero-length pair leaving the chain gives a zero angle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cm[STEPS].valid && cm[STEPS].zero && adv) |=> (out_angle_deg == '0))
    else $error("zero-length pair gave a nonzero angle");

  // The input is held off exactly when a result is held back.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_valid && !m1_r.valid && !cm[STEPS].valid)
    else $error("valid bit survived reset");

endmodule

// File: bench/tb_angle_between_vectors_2d.sv
// Testbench for the 2D vector angle block: directed and random vector pairs against a predictor.
`timescale 1ns / 1ps
module tb_angle_between_vectors_2d;

  // The block's pipeline is 29 stages deep. After the last result, the run
  // waits a little longer than that before it ends.
  localparam int unsigned PIPE_DEPTH = 29;
  localparam int unsigned N_RANDOM   = 430;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_stall;
  logic signed [abv2d_pkg::COMP_W-1:0]   in_a_x;
  logic signed [abv2d_pkg::COMP_W-1:0]   in_a_z;
  logic signed [abv2d_pkg::COMP_W-1:0]   in_b_x;
  logic signed [abv2d_pkg::COMP_W-1:0]   in_b_z;
  logic                                  out_valid;
  logic                                  out_stall;
  logic [abv2d_pkg::ANGLE_W-1:0]         out_angle_deg;

  // Angles that are still on their way through the pipeline, oldest first.
  logic [abv2d_pkg::ANGLE_W-1:0] angle_q[$];
  int                 n_errors;
  int                 burst_left;
  int unsigned        cyc;

  angle_between_vectors_2d u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_a_x        (in_a_x),
    .in_a_z        (in_a_z),
    .in_b_x        (in_b_x),
    .in_b_z        (in_b_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_angle_deg (out_angle_deg)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Predicts the angle for one pair of vectors. The dot and cross products
  // are exact; the pair is turned by -90 degrees when the dot product is
  // negative, scaled so that its larger coordinate has its leading one at
  // NORM_BIT, and then run through a vectoring CORDIC in degrees.
  function automatic logic [abv2d_pkg::ANGLE_W-1:0] angle_of(
    input logic signed [abv2d_pkg::COMP_W-1:0] ax,
    input logic signed [abv2d_pkg::COMP_W-1:0] az,
    input logic signed [abv2d_pkg::COMP_W-1:0] bx,
    input logic signed [abv2d_pkg::COMP_W-1:0] bz);
    longint          dot;
    longint          crs;
    longint unsigned mag_dot;
    longint unsigned mag_crs;
    longint unsigned ux;
    longint unsigned uy;
    longint unsigned lead;
    longint          x;
    longint          y;
    longint          z;
    longint          xs;
    longint          ys;
    longint unsigned rounded;
    dot     = longint'(ax) * longint'(bx) + longint'(az) * longint'(bz);
    crs     = longint'(ax) * longint'(bz) - longint'(az) * longint'(bx);
    mag_dot = (dot < 0) ? longint'(-dot) : dot;
    mag_crs = (crs < 0) ? longint'(-crs) : crs;
    // A zero-length vector counts as a cosine of one.
    if (mag_dot == 0 && mag_crs == 0) return '0;
    if (dot < 0) begin
      ux = mag_crs;
      uy = mag_dot;
      z  = longint'(90) <<< abv2d_pkg::ZFRAC;
    end else begin
      ux = mag_dot;
      uy = mag_crs;
      z  = 0;
    end
    lead = (ux > uy) ? ux : uy;
    while (lead >= (64'd1 << (abv2d_pkg::NORM_BIT + 1))) begin
      ux   = ux >> 1;
      uy   = uy >> 1;
      lead = lead >> 1;
    end
    while (lead < (64'd1 << abv2d_pkg::NORM_BIT)) begin
      ux   = ux << 1;
      uy   = uy << 1;
      lead = lead << 1;
    end
    x = ux;
    y = uy;
    for (int i = 0; i < abv2d_pkg::STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(abv2d_pkg::ATAN_Q22[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(abv2d_pkg::ATAN_Q22[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(180) <<< abv2d_pkg::ZFRAC)) z = longint'(180) <<< abv2d_pkg::ZFRAC;
    rounded = (longint'(z) + (64'd1 << (abv2d_pkg::RND_SH - 1))) >> abv2d_pkg::RND_SH;
    if (rounded > abv2d_pkg::ANG_MAX) rounded = abv2d_pkg::ANG_MAX;
    return rounded[abv2d_pkg::ANGLE_W-1:0];
  endfunction

  // Every accepted item gets its expected angle queued at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      angle_q.push_back(angle_of(in_a_x, in_a_z, in_b_x, in_b_z));
    end
  end

  // Every accepted result is compared with the oldest expected angle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (angle_q.size() == 0) begin
        $error("angle_deg: no item pending, got %0d", out_angle_deg);
        n_errors++;
      end else if (angle_q[0] !== out_angle_deg) begin
        $error("angle_deg: expected %0d, got %0d", angle_q[0], out_angle_deg);
        n_errors++;
        void'(angle_q.pop_front());
      end else begin
        void'(angle_q.pop_front());
      end
    end
  end

  // The receiver stalls on its own pattern: one window in four never
  // stalls, the others stall about a third of the time.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc[8:7] == 2'd0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 35);
    end
  end

  // Sends one item. The sender works in bursts; between bursts it leaves
  // in_valid low for a random number of cycles.
  task automatic send_pair(input logic signed [abv2d_pkg::COMP_W-1:0] ax,
                           input logic signed [abv2d_pkg::COMP_W-1:0] az,
                           input logic signed [abv2d_pkg::COMP_W-1:0] bx,
                           input logic signed [abv2d_pkg::COMP_W-1:0] bz);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      for (int i = 0; i < gap; i++) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_a_x   <= ax;
    in_a_z   <= az;
    in_b_x   <= bx;
    in_b_z   <= bz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the input idle until every queued angle has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (angle_q.size() != 0) @(posedge clk);
  endtask

  // A zero-length vector on either side, or both, gives zero.
  task automatic test_zero_length();
    send_pair(16'sd0, 16'sd0, 16'sd256, 16'sd512);
    send_pair(-16'sd300, 16'sd77, 16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd0, -16'sd32768, -16'sd32768);
  endtask

  // Components at the ends of their range, where products are largest.
  task automatic test_extremes();
    send_pair(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_pair(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_pair(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_pair(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768);
    send_pair(16'sd1, 16'sd0, 16'sd0, 16'sd1);
    send_pair(16'sd1, 16'sd1, -16'sd32768, 16'sd32767);
    send_pair(-16'sd1, 16'sd0, 16'sd32767, 16'sd0);
  endtask

  // Parallel, antiparallel, perpendicular and diagonal pairs, where the
  // clamps at 0 and 180 degrees and the 90 degree turn come into play.
  task automatic test_special_angles();
    send_pair(16'sd256, 16'sd0, 16'sd512, 16'sd0);
    send_pair(16'sd256, 16'sd256, 16'sd1024, 16'sd1024);
    send_pair(16'sd256, 16'sd0, -16'sd256, 16'sd0);
    send_pair(-16'sd700, 16'sd350, 16'sd1400, -16'sd700);
    send_pair(16'sd256, 16'sd0, 16'sd0, 16'sd256);
    send_pair(16'sd0, -16'sd256, 16'sd256, 16'sd0);
    send_pair(16'sd256, 16'sd0, 16'sd256, 16'sd256);
    send_pair(16'sd256, 16'sd0, -16'sd256, 16'sd256);
    send_pair(16'sd256, 16'sd0, -16'sd256, 16'sd1);
    send_pair(16'sd256, 16'sd0, 16'sd256, -16'sd1);
  endtask

  // Random pairs: mostly full-range components, some small, and some that
  // are scaled copies or quarter turns of the first vector.
  task automatic test_random_pairs(input int count);
    logic signed [abv2d_pkg::COMP_W-1:0] ax;
    logic signed [abv2d_pkg::COMP_W-1:0] az;
    logic signed [abv2d_pkg::COMP_W-1:0] bx;
    logic signed [abv2d_pkg::COMP_W-1:0] bz;
    int                       kind;
    int                       k;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      ax   = $urandom;
      az   = $urandom;
      bx   = $urandom;
      bz   = $urandom;
      if (kind == 6) begin
        ax = $signed(10'($urandom)) >>> 2;
        az = $signed(10'($urandom)) >>> 2;
        bx = $signed(10'($urandom)) >>> 2;
        bz = $signed(10'($urandom)) >>> 2;
      end else if (kind == 7 || kind == 8) begin
        ax = $signed(12'($urandom));
        az = $signed(12'($urandom));
        k  = $urandom_range(1, 7);
        if (kind == 7) begin
          bx = (($urandom_range(0, 1) != 0) ? -k : k) * ax;
          bz = (bx / ((ax == 0) ? 1 : ax)) * az;
          if (ax == 0) bz = k * az;
        end else begin
          bx = -az * k;
          bz = ax * k;
        end
      end
      send_pair(ax, az, bx, bz);
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_a_x     <= '0;
    in_a_z     <= '0;
    in_b_x     <= '0;
    in_b_z     <= '0;
    out_stall  <= 1'b0;
    cyc        = 0;
    n_errors   = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_length();
    test_extremes();
    test_special_angles();
    // Let the pipeline empty completely once before the random part.
    wait_drained();
    test_random_pairs(N_RANDOM / 2);
    wait_drained();
    test_random_pairs(N_RANDOM - N_RANDOM / 2);

    wait_drained();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (n_errors == 0 && angle_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // A watchdog ends the run with a failure if it has not finished by this time.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
